// ----- src/csfsr_pkg.sv -----
// shared constants and types for the checksum frame sync receiver
package csfsr_pkg;

    localparam int FRAME_BYTES_DEFAULT = 11;
    localparam int BYTE_W              = 8;
    localparam int WORD_W              = 32;

    // frame status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // outcome of one byte step in the window
    typedef struct packed {
        logic has_result;
        logic status;
    } step_t;

endpackage

// ----- src/csfsr_window.sv -----
// sliding byte window with running checksum and frame decode
module csfsr_window #(
    parameter int FRAME_BYTES = csfsr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  logic [csfsr_pkg::BYTE_W-1:0]            byte_in,
    output csfsr_pkg::step_t                        outcome,
    output logic signed [csfsr_pkg::WORD_W-1:0]     speed,
    output logic signed [csfsr_pkg::WORD_W-1:0]     current
);

    localparam int HOLD  = FRAME_BYTES - 1;
    localparam int CNT_W = $clog2(FRAME_BYTES);

    logic [csfsr_pkg::BYTE_W-1:0] window_reg  [HOLD];
    logic [csfsr_pkg::BYTE_W-1:0] window_next [HOLD];
    logic [CNT_W-1:0]             fill_reg;
    logic [CNT_W-1:0]             fill_next;
    logic [csfsr_pkg::BYTE_W-1:0] sum_reg;
    logic [csfsr_pkg::BYTE_W-1:0] sum_next;
    logic                         full;
    logic                         mismatch;
    logic [csfsr_pkg::BYTE_W-1:0] frame_b [1:8];

    // window full means this byte closes a frame
    assign full     = (fill_reg == CNT_W'(HOLD));
    assign mismatch = (sum_reg != byte_in);

    assign outcome.has_result = full;
    assign outcome.status     = mismatch ? csfsr_pkg::STATUS_MISMATCH : csfsr_pkg::STATUS_OK;

    // frame byte view: held bytes, then the incoming byte, then zero
    for (genvar k = 1; k <= 8; k++)
    begin : g_frame
        if (k < HOLD)
        begin : g_held
            assign frame_b[k] = window_reg[k];
        end
        else if (k == HOLD)
        begin : g_last
            assign frame_b[k] = byte_in;
        end
        else
        begin : g_pad
            assign frame_b[k] = '0;
        end
    end

    // big-endian payload words, zero on mismatch
    always_comb
    begin
        if (mismatch)
        begin
            speed   = '0;
            current = '0;
        end
        else
        begin
            speed   = {frame_b[1], frame_b[2], frame_b[3], frame_b[4]};
            current = {frame_b[5], frame_b[6], frame_b[7], frame_b[8]};
        end
    end

    // next window, count and running sum
    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        if (step)
        begin
            if (!full)
            begin
                for (int i = 0; i < HOLD; i++)
                begin
                    if (fill_reg == CNT_W'(i))
                    begin
                        window_next[i] = byte_in;
                    end
                end
                fill_next = fill_reg + 1'b1;
                sum_next  = sum_reg + byte_in;
            end
            else if (mismatch)
            begin
                for (int i = 0; i < HOLD - 1; i++)
                begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[HOLD-1] = byte_in;
                sum_next            = sum_reg - window_reg[0] + byte_in;
            end
            else
            begin
                fill_next = '0;
                sum_next  = '0;
            end
        end
    end

    // window storage
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    // count and sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

// ----- src/checksum_frame_sync_receiver.sv -----
// top level of the checksum frame sync receiver
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, rx_byte                  | request in
//  out     | out_valid, out_stall, frame_status,          | request out
//          | speed_raw, current_raw                       |
//
// one byte per cycle unless a stalled result holds the decode stage;
// a byte is registered on accept, then decoded into the result register
// the checksum is a running sum kept beside the window, so an add, a
// subtract and one compare set the per-byte path
// reset clears the fill count, the sum and all valid flags
// a stalled result holds the decode stage only when that byte makes a result
module checksum_frame_sync_receiver #(
    parameter int FRAME_BYTES = csfsr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [csfsr_pkg::BYTE_W-1:0]            rx_byte,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    frame_status,
    output logic signed [csfsr_pkg::WORD_W-1:0]     speed_raw,
    output logic signed [csfsr_pkg::WORD_W-1:0]     current_raw
);

    logic                                in_valid_reg;
    logic                                in_valid_next;
    logic [csfsr_pkg::BYTE_W-1:0]        byte_reg;
    logic                                in_accept;
    logic                                go;
    logic                                load_out;
    csfsr_pkg::step_t                    outcome;
    logic signed [csfsr_pkg::WORD_W-1:0] speed;
    logic signed [csfsr_pkg::WORD_W-1:0] current;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                status_reg;
    logic signed [csfsr_pkg::WORD_W-1:0] speed_reg;
    logic signed [csfsr_pkg::WORD_W-1:0] current_reg;

    // decode advances unless its result has nowhere to go
    assign go        = in_valid_reg && (!outcome.has_result || !out_valid_reg || !out_stall);
    assign load_out  = go && outcome.has_result;
    assign in_stall  = in_valid_reg && !go;
    assign in_accept = in_valid && !in_stall;

    csfsr_window #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (go),
        .byte_in (byte_reg),
        .outcome (outcome),
        .speed   (speed),
        .current (current)
    );

    // valid flag next values
    always_comb
    begin
        in_valid_next = in_stall ? 1'b1 : in_accept;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input byte register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg  <= outcome.status;
            speed_reg   <= speed;
            current_reg <= current;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign speed_raw    = speed_reg;
    assign current_raw  = current_reg;

endmodule

// ----- src/csfsr_checker.sv -----
// port-level checks for the checksum frame sync receiver
module csfsr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                frame_status,
    input logic signed [csfsr_pkg::WORD_W-1:0] speed_raw,
    input logic signed [csfsr_pkg::WORD_W-1:0] current_raw
);

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input stall only comes from a stalled pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a fresh result traces back to an accepted byte request
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching byte request");

    // mismatch carries zero payload
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == csfsr_pkg::STATUS_MISMATCH
            |-> speed_raw == '0 && current_raw == '0)
        else $error("nonzero payload on checksum mismatch");

endmodule

bind checksum_frame_sync_receiver csfsr_checker u_csfsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .speed_raw    (speed_raw),
    .current_raw  (current_raw)
);
